### src/skgl_pkg.sv
// ----------------------------------------------------------------------------
// Soft-knee gain limiter package
// Shared widths, fixed-point constants and elaboration-time table helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package skgl_pkg;

    localparam int POWER_W  = 24;
    localparam int RECIP_W  = 24;
    localparam int SOFT_W   = 32;
    localparam int GAIN_W   = 17;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam int STEP_SHIFT = 6;
    localparam int STEP_W     = 17;
    localparam logic [STEP_W-1:0] STEP_MAX = 17'd131071;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_RECIP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KNEE_SOFTNESS   = 2'd1;

    localparam logic [RECIP_W-1:0] RECIP_RESET = 24'd65536;
    localparam logic [SOFT_W-1:0]  SOFT_RESET  = 32'd1678;

    localparam logic [28:0] LOG2_UNIT_Q24   = 29'(STEP_SHIFT) << 24;
    localparam logic [31:0] DB_PER_LOG2_Q30 = 32'd3232284966;
    localparam logic [28:0] EXP_PER_DB_Q32  = 29'd356689313;
    localparam logic [30:0] ONE_Q30         = 31'd1 << 30;
    localparam logic [GAIN_W-1:0] GAIN_UNITY = 17'd65536;

    localparam int LOG_STAGES  = 24;
    localparam int SQRT_STAGES = 31;
    localparam int EXP_STAGES  = 24;
    localparam int LATENCY     = 87;

    function automatic logic [63:0] isqrt_c(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] x;
        r = '0;
        x = v;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] exp_tab(input int idx);
        logic [63:0] t;
        t = isqrt_c(64'd1 << 59);
        for (int j = 1; j < idx; j++)
            t = isqrt_c(t << 30);
        return t;
    endfunction

endpackage

`default_nettype wire

### src/soft_knee_gain_limiter.sv
// ----------------------------------------------------------------------------
// Soft-knee gain limiter
// Envelope power to gain through a log, soft-knee and exponent pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   An item enters with start high while busy is low; busy never rises, so
//   one sample can enter on every clock cycle.
//   Each result appears on gain for one cycle with done high. The receiver
//   cannot stall the block. The pipeline holds the 24 squaring stages of
//   the log, the 31 one-bit stages of the square root and the 24 multiply
//   stages of the exponent, plus eight stages of scaling and rounding.
//   threshold_recip (index 0) and knee_softness (index 1) are written on
//   the configuration channel; cfg_ready is always high. Write them only
//   while no sample is in flight. Other indexes are ignored.
//   Reset clears the pipeline valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module soft_knee_gain_limiter
    import skgl_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [POWER_W-1:0]    sample_power,
    output logic                       done,
    output logic [GAIN_W-1:0]          gain,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic [RECIP_W-1:0] recip_reg;
    logic [SOFT_W-1:0]  soft_reg;
    logic [LATENCY-1:0] vld_reg;
    logic               z_reg [1:LATENCY-1];

    logic [47:0] prod_reg;

    logic [30:0] lg_m_reg [0:LOG_STAGES];
    logic [4:0]  lg_p_reg [0:LOG_STAGES];
    logic [23:0] lg_f_reg [0:LOG_STAGES];

    logic [28:0] mag_reg;
    logic        mag_neg_reg;
    logic [29:0] dmag_reg;
    logic        dmag_neg_reg;

    logic [61:0] sq_v_reg [0:SQRT_STAGES];
    logic [61:0] sq_r_reg [0:SQRT_STAGES];
    logic [29:0] sq_d_reg [0:SQRT_STAGES];
    logic        sq_n_reg [0:SQRT_STAGES];

    logic [31:0] s_reg;

    logic [30:0] ex_g_reg [0:EXP_STAGES];
    logic [23:0] ex_f_reg [0:EXP_STAGES];
    logic [4:0]  ex_n_reg [0:EXP_STAGES];

    logic [GAIN_W-1:0] gain_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign done      = vld_reg[LATENCY-1];
    assign gain      = gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recip_reg <= RECIP_RESET;
            soft_reg  <= SOFT_RESET;
            vld_reg   <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_THRESHOLD_RECIP: recip_reg <= cfg_data[RECIP_W-1:0];
                    REG_KNEE_SOFTNESS:   soft_reg  <= cfg_data[SOFT_W-1:0];
                    default:             ;
                endcase
            end
            vld_reg <= {vld_reg[LATENCY-2:0], start && !busy};
        end
    end

    // Product and step quantization with leading-one normalization.
    logic [21:0]       step_raw;
    logic [STEP_W-1:0] step;
    logic [4:0]        msb;
    logic [30:0]       norm_m;

    always_comb
    begin
        step_raw = prod_reg[47:32-STEP_SHIFT];
        step     = (step_raw > 22'(STEP_MAX)) ? STEP_MAX : step_raw[STEP_W-1:0];
        msb      = '0;
        for (int i = 0; i < STEP_W; i++)
        begin
            if (step[i])
                msb = 5'(i);
        end
        norm_m = 31'(step) << (5'd30 - msb);
    end

    always_ff @(posedge clk)
    begin
        prod_reg    <= 48'(sample_power) * 48'(recip_reg);
        lg_m_reg[0] <= norm_m;
        lg_p_reg[0] <= msb;
        lg_f_reg[0] <= '0;
        z_reg[1]    <= (step == '0);
        for (int i = 2; i < LATENCY; i++)
            z_reg[i] <= z_reg[i-1];
    end

    for (genvar k = 0; k < LOG_STAGES; k++)
    begin : g_log
        logic [61:0] sq;
        logic [31:0] t;
        always_comb
        begin
            sq = 62'(lg_m_reg[k]) * 62'(lg_m_reg[k]);
            t  = sq[61:30];
        end
        always_ff @(posedge clk)
        begin
            lg_m_reg[k+1] <= t[31] ? t[31:1] : t[30:0];
            lg_p_reg[k+1] <= lg_p_reg[k];
            lg_f_reg[k+1] <= lg_f_reg[k] | (t[31] ? (24'd1 << (LOG_STAGES-1-k)) : 24'd0);
        end
    end

    logic [28:0] ls;
    logic [60:0] dprod;
    logic [61:0] sq0;

    always_comb
    begin
        ls    = {lg_p_reg[LOG_STAGES], lg_f_reg[LOG_STAGES]};
        dprod = 61'(mag_reg) * 61'(DB_PER_LOG2_Q30) + (61'd1 << 29);
        sq0   = 62'(dmag_reg) * 62'(dmag_reg) + (62'(soft_reg) << 24);
    end

    always_ff @(posedge clk)
    begin
        mag_neg_reg  <= ls < LOG2_UNIT_Q24;
        mag_reg      <= (ls < LOG2_UNIT_Q24) ? LOG2_UNIT_Q24 - ls : ls - LOG2_UNIT_Q24;
        dmag_reg     <= dprod[59:30];
        dmag_neg_reg <= mag_neg_reg;
        sq_v_reg[0]  <= sq0;
        sq_r_reg[0]  <= '0;
        sq_d_reg[0]  <= dmag_reg;
        sq_n_reg[0]  <= dmag_neg_reg;
    end

    for (genvar k = 0; k < SQRT_STAGES; k++)
    begin : g_sqrt
        localparam logic [61:0] BIT = 62'd1 << (60 - 2*k);
        logic [61:0] trial;
        assign trial = sq_r_reg[k] + BIT;
        always_ff @(posedge clk)
        begin
            if (sq_v_reg[k] >= trial)
            begin
                sq_v_reg[k+1] <= sq_v_reg[k] - trial;
                sq_r_reg[k+1] <= (sq_r_reg[k] >> 1) + BIT;
            end
            else
            begin
                sq_v_reg[k+1] <= sq_v_reg[k];
                sq_r_reg[k+1] <= sq_r_reg[k] >> 1;
            end
            sq_d_reg[k+1] <= sq_d_reg[k];
            sq_n_reg[k+1] <= sq_n_reg[k];
        end
    end

    logic [31:0] root;
    logic [31:0] dext;
    logic [60:0] eprod;

    always_comb
    begin
        root  = sq_r_reg[SQRT_STAGES][31:0];
        dext  = 32'(sq_d_reg[SQRT_STAGES]);
        eprod = 61'(s_reg) * 61'(EXP_PER_DB_Q32) + (61'd1 << 31);
    end

    always_ff @(posedge clk)
    begin
        if (sq_n_reg[SQRT_STAGES])
            s_reg <= (root >= dext) ? root - dext : '0;
        else
            s_reg <= root + dext;
        ex_g_reg[0] <= ONE_Q30;
        ex_f_reg[0] <= eprod[55:32];
        ex_n_reg[0] <= eprod[60:56];
    end

    for (genvar k = 0; k < EXP_STAGES; k++)
    begin : g_exp
        localparam logic [30:0] TK = 31'(exp_tab(k + 1));
        logic [61:0] gp;
        assign gp = 62'(ex_g_reg[k]) * 62'(TK);
        always_ff @(posedge clk)
        begin
            ex_g_reg[k+1] <= ex_f_reg[k][EXP_STAGES-1-k] ? gp[60:30] : ex_g_reg[k];
            ex_f_reg[k+1] <= ex_f_reg[k];
            ex_n_reg[k+1] <= ex_n_reg[k];
        end
    end

    logic [5:0]  sh;
    logic [63:0] rnd;

    always_comb
    begin
        sh  = 6'd14 + 6'(ex_n_reg[EXP_STAGES]);
        rnd = (64'(ex_g_reg[EXP_STAGES]) + (64'd1 << (sh - 6'd1))) >> sh;
    end

    always_ff @(posedge clk)
    begin
        gain_reg <= z_reg[LATENCY-2] ? GAIN_UNITY : rnd[GAIN_W-1:0];
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("Result beat without a matching input beat.");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> gain <= GAIN_UNITY)
        else $error("Gain above unity.");

    assert property (@(posedge clk) disable iff (!rst_n)
        $past(start && !busy && sample_power == '0, LATENCY) |-> done && gain == GAIN_UNITY)
        else $error("Zero power did not give unity gain.");

endmodule

`default_nettype wire
